// ===== design/clock_replacement_cache_core_defines.svh =====
// ============================================================================
// clock replacement cache core assertion macros
// concurrent property helpers used by the asserting top-level core
// ============================================================================
`ifndef CLOCK_REPLACEMENT_CACHE_CORE_DEFINES_SVH
`define CLOCK_REPLACEMENT_CACHE_CORE_DEFINES_SVH

// same-cycle implication, checked on clk outside reset
`define CCR_ASSERT_IMP(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("ccr same-cycle check failed");

// next-cycle implication, checked on clk outside reset
`define CCR_ASSERT_NXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("ccr next-cycle check failed");

`endif

// ===== design/ccr_pkg.sv =====
// ============================================================================
// ccr_pkg
// shared types, codes and constants of the clock replacement cache
// ============================================================================
`default_nettype none

package ccr_pkg;

    localparam int KEY_W       = 32;
    localparam int REQ_W       = 2;
    localparam int SLOT_W      = 4;
    localparam int CFG_W       = 5;
    localparam int ENTRIES_DEF = 16;
    localparam int QUEUE_DEPTH = 2;

    localparam logic [CFG_W-1:0] CAP_RESET = CFG_W'(16);

    // request codes on the input
    localparam logic [REQ_W-1:0] REQ_GET = 2'd0;
    localparam logic [REQ_W-1:0] REQ_PUT = 2'd1;
    localparam logic [REQ_W-1:0] REQ_AGE = 2'd2;
    localparam logic [REQ_W-1:0] REQ_NOP = 2'd3;

    typedef enum logic [1:0] {
        OP_GET,
        OP_PUT,
        OP_AGE,
        OP_NOP
    } op_t;

    typedef enum logic [2:0] {
        BK_IDLE,
        BK_SEARCH,
        BK_SWEEP,
        BK_EVICT,
        BK_DONE
    } back_state_t;

    typedef struct packed {
        logic [REQ_W-1:0] req_type;
        logic [KEY_W-1:0] key;
    } in_item_t;

    typedef struct packed {
        logic              hit;
        logic [SLOT_W-1:0] slot;
        logic              evicted_valid;
        logic [KEY_W-1:0]  evicted_key;
    } out_item_t;

    typedef struct packed {
        op_t              op;
        logic [KEY_W-1:0] key;
    } cmd_t;

endpackage

`default_nettype wire

// ===== design/ccr_fifo.sv =====
// ============================================================================
// ccr_fifo
// small synchronous queue with full and empty flags
// ============================================================================
`default_nettype none

module ccr_fifo
    import ccr_pkg::*;
#(
    parameter int DEPTH = QUEUE_DEPTH,
    parameter int WIDTH = 1
)
(
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             wr_en,
    input  wire logic [WIDTH-1:0] wr_data,
    output logic                  full,
    input  wire logic             rd_en,
    output logic      [WIDTH-1:0] rd_data,
    output logic                  empty
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] store [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic             do_wr, do_rd;

    assign full    = (count_reg == CNT_W'(DEPTH));
    assign empty   = (count_reg == '0);
    assign do_wr   = wr_en && !full;
    assign do_rd   = rd_en && !empty;
    assign rd_data = store[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_wr)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + PTR_W'(1);
        end
        if (do_rd)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + PTR_W'(1);
        end
        if (do_wr && !do_rd)
        begin
            count_next = count_reg + CNT_W'(1);
        end
        else if (do_rd && !do_wr)
        begin
            count_next = count_reg - CNT_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_wr)
        begin
            store[wr_ptr_reg] <= wr_data;
        end
    end

endmodule

`default_nettype wire

// ===== design/ccr_front.sv =====
// ============================================================================
// ccr_front
// takes requests, decodes the request code and queues commands for the back
// ============================================================================
`default_nettype none

module ccr_front
    import ccr_pkg::*;
(
    input  wire logic     clk,
    input  wire logic     rst_n,
    input  wire logic     push,
    output logic          full,
    input  wire in_item_t in_item,
    input  wire logic     cmd_pop,
    output cmd_t          cmd,
    output logic          cmd_empty
);

    cmd_t                 cmd_in;
    logic [$bits(cmd_t)-1:0] cmd_q;

    always_comb
    begin
        cmd_in.key = in_item.key;
        unique case (in_item.req_type)
            REQ_GET: cmd_in.op = OP_GET;
            REQ_PUT: cmd_in.op = OP_PUT;
            REQ_AGE: cmd_in.op = OP_AGE;
            REQ_NOP: cmd_in.op = OP_NOP;
        endcase
    end

    ccr_fifo #(
        .DEPTH (QUEUE_DEPTH),
        .WIDTH ($bits(cmd_t))
    ) u_cmd_fifo (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr_en   (push),
        .wr_data (cmd_in),
        .full    (full),
        .rd_en   (cmd_pop),
        .rd_data (cmd_q),
        .empty   (cmd_empty)
    );

    assign cmd = cmd_t'(cmd_q);

endmodule

`default_nettype wire

// ===== design/ccr_back.sv =====
// ============================================================================
// ccr_back
// key memory, reference bits and clock hand; runs one command at a time
// ============================================================================
`default_nettype none

module ccr_back
    import ccr_pkg::*;
#(
    parameter  int ENTRIES = ENTRIES_DEF,
    localparam int IDX_W   = (ENTRIES > 1) ? $clog2(ENTRIES) : 1,
    localparam int CNT_W   = $clog2(ENTRIES + 1)
)
(
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic [CNT_W-1:0] cap,
    input  wire cmd_t             cmd,
    input  wire logic             cmd_empty,
    output logic                  cmd_pop,
    input  wire logic             res_full,
    output logic                  res_push,
    output out_item_t             res
);

    back_state_t      state_reg, state_next;
    op_t              op_reg, op_next;
    logic [KEY_W-1:0] key_reg, key_next;
    logic [CNT_W-1:0] idx_reg, idx_next;
    logic             cmp_vld_reg, cmp_vld_next;
    logic [IDX_W-1:0] cmp_idx_reg, cmp_idx_next;
    logic [IDX_W-1:0] hand_reg, hand_next;
    logic [CNT_W-1:0] fill_reg, fill_next;
    logic [ENTRIES-1:0] ref_reg, ref_next;
    out_item_t        res_reg, res_next;
    logic [KEY_W-1:0] rd_data_reg;

    logic [KEY_W-1:0] key_mem [ENTRIES];

    logic             issue, match, scan_done, room;
    logic [CNT_W-1:0] hand_ext;
    logic [IDX_W-1:0] hand_start, hand_inc;
    logic             sweep_ref;
    logic [IDX_W-1:0] rd_addr, mem_waddr;
    logic             mem_we;

    // one memory read per cycle: search pointer while scanning, else the hand
    assign issue     = (state_reg == BK_SEARCH) && (idx_reg < fill_reg);
    assign match     = cmp_vld_reg && (rd_data_reg == key_reg);
    assign scan_done = !cmp_vld_reg && !issue;
    assign room      = (fill_reg < cap);
    assign hand_ext  = CNT_W'(hand_reg);
    assign hand_start = (hand_ext < cap) ? hand_reg : '0;
    assign hand_inc  = ((hand_ext + CNT_W'(1)) >= cap) ? '0 : hand_reg + IDX_W'(1);
    assign sweep_ref = ref_reg[hand_reg];
    assign rd_addr   = issue ? idx_reg[IDX_W-1:0] : hand_reg;

    assign res      = res_reg;
    assign cmd_pop  = (state_reg == BK_IDLE) && !cmd_empty;
    assign res_push = (state_reg == BK_DONE) && !res_full;

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            BK_IDLE:
            begin
                if (!cmd_empty)
                begin
                    state_next = (cmd.op == OP_GET || cmd.op == OP_PUT) ? BK_SEARCH : BK_DONE;
                end
            end
            BK_SEARCH:
            begin
                if (match)
                begin
                    state_next = BK_DONE;
                end
                else if (scan_done)
                begin
                    state_next = (op_reg == OP_PUT && !room) ? BK_SWEEP : BK_DONE;
                end
            end
            BK_SWEEP:
            begin
                if (!sweep_ref)
                begin
                    state_next = BK_EVICT;
                end
            end
            BK_EVICT:
            begin
                state_next = BK_DONE;
            end
            BK_DONE:
            begin
                if (!res_full)
                begin
                    state_next = BK_IDLE;
                end
            end
            default:
            begin
                state_next = BK_IDLE;
            end
        endcase
    end

    always_comb
    begin
        op_next      = op_reg;
        key_next     = key_reg;
        idx_next     = idx_reg;
        cmp_vld_next = 1'b0;
        cmp_idx_next = cmp_idx_reg;
        hand_next    = hand_reg;
        fill_next    = fill_reg;
        ref_next     = ref_reg;
        res_next     = res_reg;
        mem_we       = 1'b0;
        mem_waddr    = cmp_idx_reg;
        unique case (state_reg)
            BK_IDLE:
            begin
                if (!cmd_empty)
                begin
                    op_next  = cmd.op;
                    key_next = cmd.key;
                    idx_next = '0;
                    res_next = '0;
                    if (cmd.op == OP_AGE)
                    begin
                        ref_next = '0;
                    end
                end
            end
            BK_SEARCH:
            begin
                if (issue)
                begin
                    idx_next     = idx_reg + CNT_W'(1);
                    cmp_vld_next = 1'b1;
                    cmp_idx_next = idx_reg[IDX_W-1:0];
                end
                if (match)
                begin
                    ref_next[cmp_idx_reg] = 1'b1;
                    res_next.hit          = 1'b1;
                    res_next.slot         = SLOT_W'(cmp_idx_reg);
                end
                else if (scan_done && op_reg == OP_PUT)
                begin
                    if (room)
                    begin
                        // free slot left: append at the fill point
                        mem_we    = 1'b1;
                        mem_waddr = fill_reg[IDX_W-1:0];
                        ref_next[fill_reg[IDX_W-1:0]] = 1'b1;
                        fill_next = fill_reg + CNT_W'(1);
                        res_next.slot = SLOT_W'(fill_reg[IDX_W-1:0]);
                    end
                    else
                    begin
                        hand_next = hand_start;
                    end
                end
            end
            BK_SWEEP:
            begin
                hand_next = hand_inc;
                if (sweep_ref)
                begin
                    ref_next[hand_reg] = 1'b0;
                end
                else
                begin
                    cmp_idx_next = hand_reg;
                end
            end
            BK_EVICT:
            begin
                mem_we                 = 1'b1;
                ref_next[cmp_idx_reg]  = 1'b1;
                res_next.slot          = SLOT_W'(cmp_idx_reg);
                res_next.evicted_valid = 1'b1;
                res_next.evicted_key   = rd_data_reg;
            end
            BK_DONE:
            begin
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= BK_IDLE;
            cmp_vld_reg <= 1'b0;
            hand_reg    <= '0;
            fill_reg    <= '0;
            ref_reg     <= '0;
        end
        else
        begin
            state_reg   <= state_next;
            cmp_vld_reg <= cmp_vld_next;
            hand_reg    <= hand_next;
            fill_reg    <= fill_next;
            ref_reg     <= ref_next;
        end
    end

    always_ff @(posedge clk)
    begin
        op_reg      <= op_next;
        key_reg     <= key_next;
        idx_reg     <= idx_next;
        cmp_idx_reg <= cmp_idx_next;
        res_reg     <= res_next;
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            key_mem[mem_waddr] <= key_reg;
        end
        rd_data_reg <= key_mem[rd_addr];
    end

endmodule

`default_nettype wire

// ===== design/clock_replacement_cache_core.sv =====
// path: a request passes the command queue, a scan of the filled entries and the result
//   queue; a put miss with no free slot adds a sweep and an eviction before the result
// throughput: the back runs one request at a time while the command queue holds later ones;
//   lookups are set by the single read port of the key memory, scanned one entry a cycle
// reset: asynchronous, clears queues, reference bits, fill count, hand, capacity to 16;
//   key memory is not cleared and needs no clearing pass
// ============================================================================
// clock_replacement_cache_core
// key store with clock (second-chance) replacement behind queue-style ports
// ============================================================================
`default_nettype none
`include "clock_replacement_cache_core_defines.svh"

module clock_replacement_cache_core
    import ccr_pkg::*;
#(
    parameter int ENTRIES = ENTRIES_DEF
)
(
    input  wire logic             clk,
    input  wire logic             rst_n,
    // request side
    input  wire logic             push,
    output logic                  full,
    input  wire in_item_t         in_item,
    // result side
    output logic                  empty,
    input  wire logic             pop,
    output out_item_t             out_item,
    // capacity register
    input  wire logic             cfg_we,
    input  wire logic [CFG_W-1:0] cfg_wdata
);

    localparam int CNT_W = $clog2(ENTRIES + 1);
    localparam int CMP_W = (CNT_W > CFG_W) ? CNT_W : CFG_W;

    // capacity register: the user writes it only while the block is idle; the block does not enforce this
    logic [CFG_W-1:0] cfg_reg;
    logic [CNT_W-1:0] cap;

    // front to back command transfer
    cmd_t             cmd;
    logic             cmd_empty;
    logic             cmd_pop;

    // back to result queue transfer
    out_item_t        res;
    logic             res_push;
    logic             res_full;
    logic [$bits(out_item_t)-1:0] res_q;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg <= CAP_RESET;
        end
        else if (cfg_we)
        begin
            cfg_reg <= cfg_wdata;
        end
    end

    // zero acts as one, anything past the entry count is clamped
    always_comb
    begin
        priority if (cfg_reg == '0)
        begin
            cap = CNT_W'(1);
        end
        else if (CMP_W'(cfg_reg) > CMP_W'(ENTRIES))
        begin
            cap = CNT_W'(ENTRIES);
        end
        else
        begin
            cap = CNT_W'(cfg_reg);
        end
    end

    // front: decode and queue each request
    ccr_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .full      (full),
        .in_item   (in_item),
        .cmd_pop   (cmd_pop),
        .cmd       (cmd),
        .cmd_empty (cmd_empty)
    );

    // back: lookup scan, fill, sweep and evict
    ccr_back #(
        .ENTRIES (ENTRIES)
    ) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .cap       (cap),
        .cmd       (cmd),
        .cmd_empty (cmd_empty),
        .cmd_pop   (cmd_pop),
        .res_full  (res_full),
        .res_push  (res_push),
        .res       (res)
    );

    // result queue lets the back finish while the consumer stalls
    ccr_fifo #(
        .DEPTH (QUEUE_DEPTH),
        .WIDTH ($bits(out_item_t))
    ) u_res_fifo (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr_en   (res_push),
        .wr_data (res),
        .full    (res_full),
        .rd_en   (pop),
        .rd_data (res_q),
        .empty   (empty)
    );

    assign out_item = out_item_t'(res_q);

    // a result never reports both a hit and an eviction
    `CCR_ASSERT_IMP(a_hit_evict_excl, res_push, !(res.hit && res.evicted_valid))
    // an evicted slot always lies inside the current capacity
    `CCR_ASSERT_IMP(a_evict_in_cap, res_push && res.evicted_valid, res.slot < cap)
    // the back takes one command at a time
    `CCR_ASSERT_NXT(a_one_in_flight, cmd_pop, !cmd_pop)
    // each command yields exactly one result before the next is taken
    `CCR_ASSERT_NXT(a_one_result, res_push, !res_push)

endmodule

`default_nettype wire

// ===== tb/testbench.sv =====
// ============================================================================
// clock replacement cache testbench
// drives get, put, age and unused requests through the queue-style ports,
// predicts every result with a second-chance store model and checks each one
// ============================================================================
`default_nettype none

module testbench;
    import ccr_pkg::*;

    localparam int ENTRIES      = ENTRIES_DEF;
    localparam int HALF_PERIOD  = 6;
    localparam int RESET_CYCLES = 6;
    // worst case: fill scan plus two sweep passes plus queue stages
    localparam int SETTLE_CYCLES = 3 * ENTRIES + 16;
    localparam int TIMEOUT_CYCLES = 1000000;
    localparam int REPORT_LIMIT = 10;

    // ------------------------------------------------------------------------
    // clock, reset and block ports
    // ------------------------------------------------------------------------
    logic             clk       = 1'b0;
    logic             rst_n     = 1'b0;
    logic             push      = 1'b0;
    logic             full;
    in_item_t         in_item   = '0;
    logic             empty;
    logic             pop       = 1'b0;
    out_item_t        out_item;
    logic             cfg_we    = 1'b0;
    logic [CFG_W-1:0] cfg_wdata = '0;

    always #HALF_PERIOD clk = ~clk;

    clock_replacement_cache_core #(
        .ENTRIES (ENTRIES)
    ) u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .full      (full),
        .in_item   (in_item),
        .empty     (empty),
        .pop       (pop),
        .out_item  (out_item),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata)
    );

    // ------------------------------------------------------------------------
    // store model: keys, second-chance bits, fill level, hand, capacity
    // ------------------------------------------------------------------------
    logic [KEY_W-1:0]   stored_keys [ENTRIES];
    logic [ENTRIES-1:0] second_chance = '0;
    int                 fill_level    = 0;
    int                 hand_pos      = 0;
    logic [CFG_W-1:0]   capacity_reg  = CAP_RESET;

    // requests waiting to be transferred, results waiting to come back
    in_item_t  pending_requests [$];
    out_item_t expected_results [$];

    int mismatch_count = 0;
    int failure_count  = 0;

    // idling rates in percent, changed per phase
    int send_idle_pct  = 0;
    int recv_stall_pct = 0;

    // zero acts as one, anything above the entry count is clamped
    function automatic int effective_capacity();
        if (capacity_reg == 0)
            return 1;
        if (capacity_reg > ENTRIES)
            return ENTRIES;
        return int'(capacity_reg);
    endfunction

    // advance the store model by one request and return its result
    function automatic out_item_t predict_access(input in_item_t req);
        out_item_t res;
        op_t       op;
        int        cap_eff;
        int        pos;
        int        h;
        int        i;
        res     = '0;
        op      = op_t'(req.req_type);
        cap_eff = effective_capacity();
        if (op == OP_AGE)
        begin
            second_chance = '0;
            return res;
        end
        if (op == OP_NOP)
            return res;
        // lookup covers every filled entry, even past a lowered capacity
        pos = -1;
        for (i = 0; i < fill_level; i++)
        begin
            if (pos < 0 && stored_keys[i] == req.key)
                pos = i;
        end
        if (pos >= 0)
        begin
            second_chance[pos] = 1'b1;
            res.hit  = 1'b1;
            res.slot = SLOT_W'(pos);
            return res;
        end
        if (op == OP_GET)
            return res;
        // put miss while there is room: take the next free slot
        if (fill_level < cap_eff)
        begin
            stored_keys[fill_level]   = req.key;
            second_chance[fill_level] = 1'b1;
            res.slot   = SLOT_W'(fill_level);
            fill_level = fill_level + 1;
            return res;
        end
        // sweep: hand restarts at zero when it sits past the capacity
        if (hand_pos >= cap_eff)
            hand_pos = 0;
        for (i = 0; i <= 2 * cap_eff; i++)
        begin
            h        = hand_pos;
            hand_pos = (h + 1 >= cap_eff) ? 0 : h + 1;
            if (second_chance[h])
                second_chance[h] = 1'b0;
            else
            begin
                res.slot          = SLOT_W'(h);
                res.evicted_valid = 1'b1;
                res.evicted_key   = stored_keys[h];
                stored_keys[h]    = req.key;
                second_chance[h]  = 1'b1;
                return res;
            end
        end
        return res;
    endfunction

    // ------------------------------------------------------------------------
    // request driver: new values at the falling edge, transfer seen at rising
    // ------------------------------------------------------------------------
    always @(negedge clk)
    begin
        if (rst_n && pending_requests.size() > 0 && $urandom_range(99) >= send_idle_pct)
        begin
            push    <= 1'b1;
            in_item <= pending_requests[0];
        end
        else
            push <= 1'b0;
    end

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            // register write and request transfer never share a cycle
            if (cfg_we)
                capacity_reg = cfg_wdata;
            if (push && !full)
            begin
                expected_results = {expected_results, predict_access(in_item)};
                void'(pending_requests.pop_front());
            end
        end
    end

    // ------------------------------------------------------------------------
    // result monitor: random stalls on pop, compare each transfer in order
    // ------------------------------------------------------------------------
    always @(negedge clk)
    begin
        pop <= ($urandom_range(99) >= recv_stall_pct);
    end

    always @(posedge clk)
    begin
        out_item_t want;
        if (rst_n && pop && !empty)
        begin
            if (expected_results.size() == 0)
            begin
                failure_count++;
                mismatch_count++;
                if (mismatch_count <= REPORT_LIMIT)
                    $display("unexpected result: hit=%0d slot=%0d ev=%0d ekey=%h",
                             out_item.hit, out_item.slot, out_item.evicted_valid,
                             out_item.evicted_key);
            end
            else
            begin
                want = expected_results.pop_front();
                if (out_item.hit !== want.hit || out_item.slot !== want.slot ||
                    out_item.evicted_valid !== want.evicted_valid ||
                    out_item.evicted_key !== want.evicted_key)
                begin
                    failure_count++;
                    mismatch_count++;
                    if (mismatch_count <= REPORT_LIMIT)
                    begin
                        $display("mismatch: expected hit=%0d slot=%0d ev=%0d ekey=%h",
                                 want.hit, want.slot, want.evicted_valid,
                                 want.evicted_key);
                        $display("          got      hit=%0d slot=%0d ev=%0d ekey=%h",
                                 out_item.hit, out_item.slot, out_item.evicted_valid,
                                 out_item.evicted_key);
                    end
                end
            end
        end
    end

    // ------------------------------------------------------------------------
    // stimulus helpers
    // ------------------------------------------------------------------------
    task automatic queue_request(input op_t op, input logic [KEY_W-1:0] k);
        in_item_t it;
        it.req_type = op;
        it.key      = k;
        pending_requests = {pending_requests, it};
    endtask

    // let every transfer complete so the block is idle again
    task automatic drain_block();
        while (pending_requests.size() > 0 || expected_results.size() > 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
        @(negedge clk);
    endtask

    task automatic write_capacity(input logic [CFG_W-1:0] value);
        cfg_we    <= 1'b1;
        cfg_wdata <= value;
        @(negedge clk);
        cfg_we    <= 1'b0;
        @(negedge clk);
    endtask

    // mostly keys already stored or capacity plus one to four fresh ones, so hits and sweeps
    // dominate; the rest is age requests, the unused code and wide random noise
    task automatic queue_random_phase(input int count);
        logic [KEY_W-1:0] key_pool [$];
        logic [KEY_W-1:0] k;
        op_t              op;
        int               r;
        int               i;
        key_pool = {};
        for (i = 0; i < fill_level; i++)
            key_pool = {key_pool, stored_keys[i]};
        repeat (effective_capacity() + $urandom_range(1, 4))
        begin
            k        = $urandom;
            key_pool = {key_pool, k};
        end
        repeat (count)
        begin
            r = $urandom_range(99);
            k = key_pool[$urandom_range(key_pool.size() - 1)];
            if (r < 40)
                op = OP_GET;
            else if (r < 85)
                op = OP_PUT;
            else if (r < 91)
                op = OP_AGE;
            else if (r < 95)
                op = OP_NOP;
            else
            begin
                op = op_t'($urandom_range(3));
                case ($urandom_range(2))
                    0: k = '0;
                    1: k = '1;
                    default: k = $urandom;
                endcase
            end
            queue_request(op, k);
        end
    endtask

    // ------------------------------------------------------------------------
    // test sequence
    // ------------------------------------------------------------------------
    initial
    begin
        logic [CFG_W-1:0] cap_plan [12];
        int               phase;
        cap_plan = '{5'd16, 5'd1, 5'd0, 5'd31, 5'd4, 5'd16,
                     5'd3, 5'd8, 5'd17, 5'd2, 5'd12, 5'd16};

        repeat (RESET_CYCLES) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        // directed: two entries so fills, hits and sweeps come quickly
        write_capacity(5'd2);
        queue_request(OP_GET, 32'h0000_0000);   // miss on empty store
        queue_request(OP_PUT, 32'h0000_0000);
        queue_request(OP_PUT, 32'hFFFF_FFFF);
        queue_request(OP_GET, 32'hFFFF_FFFF);   // hit
        queue_request(OP_PUT, 32'h0000_0000);   // put hit
        queue_request(OP_NOP, 32'hFFFF_FFFF);   // unused code
        queue_request(OP_PUT, 32'h0000_0001);   // sweep clears both, evicts slot 0
        queue_request(OP_GET, 32'h0000_0000);   // evicted key now misses
        queue_request(OP_AGE, 32'h5555_5555);
        queue_request(OP_PUT, 32'h0000_0002);   // clear bit right at the hand
        queue_request(OP_GET, 32'h0000_0001);
        queue_request(OP_PUT, 32'h0000_0003);   // full two-pass sweep
        queue_request(OP_NOP, 32'h0000_0000);
        drain_block();

        // capacity zero acts as one, lowered below the fill level with hand past it
        write_capacity(5'd0);
        queue_request(OP_PUT, 32'h0000_0007);
        queue_request(OP_GET, 32'h0000_0002);   // entry past capacity still visible
        queue_request(OP_PUT, 32'h8000_0000);
        queue_request(OP_AGE, 32'hAAAA_AAAA);
        queue_request(OP_PUT, 32'h0000_0007);
        drain_block();

        // random phases over capacity settings and idling modes
        for (phase = 0; phase < 12; phase++)
        begin
            case (phase % 4)
                0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
                1: begin send_idle_pct = 51; recv_stall_pct = 0;  end
                2: begin send_idle_pct = 0;  recv_stall_pct = 51; end
                default: begin send_idle_pct = 6; recv_stall_pct = 6; end
            endcase
            write_capacity(cap_plan[phase]);
            queue_random_phase(130);
            drain_block();
        end

        failure_count += expected_results.size();
        if (failure_count == 0)
            $display("testbench passed");
        else
            $display("testbench failed");
        $finish;
    end

    // hard stop if the block hangs
    initial
    begin
        #(2 * HALF_PERIOD * TIMEOUT_CYCLES);
        $display("testbench failed");
        $finish;
    end

endmodule

`default_nettype wire
